>>> src/open_address_key_table_assert.svh
// Assertion macros for the key table RTL.
// Each macro takes a label, an antecedent and a consequent, clocked on clock, held off in reset.
`ifndef OPEN_ADDRESS_KEY_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_KEY_TABLE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define OAKT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define OAKT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/oakt_pkg.sv
// Shared types and constants of the open-address key table.
// No dependencies; used by the interfaces and all modules but the RAM.
package oakt_pkg;

   localparam int KEY_W = 16;
   localparam int SIZE_W = 8;
   localparam int SLOT_W = 8;
   localparam int BIT_CNT_W = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd255;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_ZERO_KEY  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_ISSUE,
      S_CHECK,
      S_RESPOND
   } state_type;

endpackage

>>> src/oakt_req_if.sv
// Request channel of the key table: valid/ready with action and key.
// Depends on oakt_pkg.
interface oakt_req_if import oakt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [KEY_W-1:0]  key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

>>> src/oakt_rsp_if.sv
// Response channel of the key table: valid/ready with status and slot.
// Depends on oakt_pkg.
interface oakt_rsp_if import oakt_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

>>> src/oakt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module oakt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> src/oakt_modstep.sv
// Shared reduce unit: brings a value below twice the modulus back under it.
// Serves both the bit-serial key remainder and the probe step. Uses oakt_pkg.
module oakt_modstep import oakt_pkg::*; (
   input  logic [SIZE_W:0]   sum,
   input  logic [SIZE_W-1:0] modulus,
   output logic [SIZE_W-1:0] result
);

   logic [SIZE_W:0] diff;

   assign diff = sum - {1'b0, modulus};
   assign result = (sum >= {1'b0, modulus}) ? diff[SIZE_W-1:0] : sum[SIZE_W-1:0];

endmodule

>>> src/open_address_key_table.sv
// A zero key answers in the cycle after acceptance; any other key runs the bit-serial remainder
// (S_DIVIDE), then S_ISSUE, then S_CHECK once per probed slot (1 to the effective slot count),
// then S_RESPOND.
// One request at a time: the next is taken after the response is handed off.
// Reset (synchronous): all slots read empty at once (per-slot valid bits), table_size = 255.
`include "open_address_key_table_assert.svh"

module open_address_key_table import oakt_pkg::*; #(
   parameter int MAX_SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   oakt_req_if.sink          req_chan,
   oakt_rsp_if.source        rsp_chan
);

   localparam int ADDR_W = $clog2(MAX_SLOTS);
   localparam logic [SIZE_W:0] MAX_N = (SIZE_W+1)'(MAX_SLOTS);

   state_type state_ff, state_in;
   logic [SIZE_W-1:0]    table_size_ff;
   logic                 action_ff, action_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SIZE_W-1:0]    n_ff, n_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [SIZE_W-1:0]    pos_ff, pos_in;
   logic [SIZE_W-1:0]    probe_ff, probe_in;
   logic [MAX_SLOTS-1:0] valid_ff, valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic [SIZE_W-1:0]    eff_n;
   logic [SIZE_W:0]      unit_sum;
   logic [SIZE_W-1:0]    unit_res;
   logic [SIZE_W-1:0]    probe_next;
   logic                 ram_we;
   logic                 ram_re;
   logic [KEY_W-1:0]     ram_rd_data;
   logic [KEY_W-1:0]     entry;
   logic                 hit;
   logic                 last_probe;

   // effective slot count: zero counts as one, clamp at the storage depth
   always_comb begin
      if (table_size_ff == '0) begin
         eff_n = SIZE_W'(1);
      end else if ({1'b0, table_size_ff} > MAX_N) begin
         eff_n = MAX_N[SIZE_W-1:0];
      end else begin
         eff_n = table_size_ff;
      end
   end

   assign probe_next = probe_ff + SIZE_W'(1);

   always_comb begin
      case (state_ff)
         S_DIVIDE: unit_sum = {rem_ff, key_ff[BIT_CNT_W'(KEY_W-1) - bit_cnt_ff]};
         S_ISSUE:  unit_sum = {1'b0, rem_ff};
         S_CHECK:  unit_sum = {1'b0, pos_ff} + {1'b0, probe_next};
         default:  unit_sum = '0;
      endcase
   end

   oakt_modstep u_modstep (
      .sum     (unit_sum),
      .modulus (n_ff),
      .result  (unit_res)
   );

   oakt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (ram_re),
      .rd_addr (unit_res[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign entry = valid_ff[pos_ff[ADDR_W-1:0]] ? ram_rd_data : '0;
   assign hit = (action_ff == ACT_INSERT) ? (entry == '0) : (entry == key_ff);
   assign last_probe = (probe_ff == n_ff - SIZE_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.key == '0) ? S_RESPOND : S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (bit_cnt_ff == BIT_CNT_W'(KEY_W-1)) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: state_in = S_CHECK;
         S_CHECK: begin
            if (hit || last_probe) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      action_in     = action_ff;
      key_in        = key_ff;
      n_in          = n_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      pos_in        = pos_ff;
      probe_in      = probe_ff;
      valid_in      = valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            action_in     = req_chan.action;
            key_in        = req_chan.key;
            n_in          = eff_n;
            rem_in        = '0;
            bit_cnt_in    = '0;
            rsp_status_in = ST_ZERO_KEY;
            rsp_slot_in   = '0;
         end
         S_DIVIDE: begin
            rem_in     = unit_res;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         end
         S_ISSUE: begin
            ram_re   = 1'b1;
            pos_in   = unit_res;
            probe_in = '0;
         end
         S_CHECK: begin
            if (hit) begin
               ram_we = (action_ff == ACT_INSERT);
               valid_in[pos_ff[ADDR_W-1:0]] = (action_ff == ACT_INSERT);
               rsp_status_in = (action_ff == ACT_INSERT) ? ST_INSERTED : ST_REMOVED;
               rsp_slot_in   = pos_ff;
            end else if (last_probe) begin
               rsp_status_in = (action_ff == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
               rsp_slot_in   = '0;
            end else begin
               // read the next probe slot speculatively
               ram_re   = 1'b1;
               pos_in   = unit_res;
               probe_in = probe_next;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = (state_ff == S_RESPOND);
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         table_size_ff <= SIZE_RESET;
         valid_ff      <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            table_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      n_ff          <= n_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      pos_ff        <= pos_in;
      probe_ff      <= probe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   `OAKT_ASSERT_NOW(a_write_in_check, ram_we, state_ff == S_CHECK && action_ff == ACT_INSERT)
   `OAKT_ASSERT_NOW(a_pos_in_range, state_ff == S_CHECK, pos_ff < n_ff && probe_ff < n_ff)
   `OAKT_ASSERT_NOW(a_fail_slot_zero,
      rsp_chan.valid && rsp_chan.status != ST_INSERTED && rsp_chan.status != ST_REMOVED,
      rsp_chan.slot == '0)
   `OAKT_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `OAKT_ASSERT_NOW(a_rem_below_n, state_ff == S_DIVIDE || state_ff == S_ISSUE, rem_ff < n_ff)

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for open_address_key_table: drives insert and remove requests over the request
// channel and checks every response against a scoreboard that models the probed key table.
// Depends on oakt_pkg, oakt_req_if, oakt_rsp_if and the open_address_key_table RTL.
module tb import oakt_pkg::*; ();

   localparam int TABLE_DEPTH = 256;
   localparam int PHASE_COUNT = 13;
   localparam int PHASE_ITEMS = 70;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int TAIL_CYCLES = 300;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } key_result_type;

   // Models the table and holds the responses still owed by the block.
   class key_table_scoreboard;
      logic [KEY_W-1:0]  slots [TABLE_DEPTH];
      logic [SIZE_W-1:0] size_reg;
      key_result_type    owed [$];
      int                errors;
      int                checked;
      int                seen [5];

      function new();
         foreach (slots[j]) slots[j] = '0;
         size_reg = SIZE_RESET;
         errors = 0;
         checked = 0;
         foreach (seen[j]) seen[j] = 0;
      endfunction

      function void set_size(logic [SIZE_W-1:0] v);
         size_reg = v;
      endfunction

      // A zero register acts as one slot.
      function int span();
         return (size_reg == '0) ? 1 : int'(size_reg);
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Return some key stored within the live slots, or zero if none.
      function logic [KEY_W-1:0] pick_stored();
         int n;
         int start;
         int j;
         logic [KEY_W-1:0] k;
         n = span();
         start = $urandom_range(n - 1);
         k = '0;
         for (j = 0; j < n && k == '0; j++) k = slots[(start + j) % n];
         return k;
      endfunction

      function void note_request(logic act, logic [KEY_W-1:0] k);
         key_result_type r;
         int n;
         int pos;
         int i;
         bit hit;
         n = span();
         r.status = (act == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
         r.slot = '0;
         hit = 1'b0;
         if (k == '0) begin
            r.status = ST_ZERO_KEY;
         end else begin
            pos = int'(k) % n;
            // The step grows by one on every probe.
            for (i = 0; i < n && !hit; i++) begin
               pos = (pos + i) % n;
               if (act == ACT_INSERT && slots[pos] == '0) begin
                  slots[pos] = k;
                  r.status = ST_INSERTED;
                  r.slot = SLOT_W'(pos);
                  hit = 1'b1;
               end else if (act == ACT_REMOVE && slots[pos] == k) begin
                  slots[pos] = '0;
                  r.status = ST_REMOVED;
                  r.slot = SLOT_W'(pos);
                  hit = 1'b1;
               end
            end
         end
         owed.push_back(r);
      endfunction

      function void check_response(status_type st, logic [SLOT_W-1:0] sl);
         key_result_type want;
         if (owed.size() == 0) begin
            $error("response with none pending: status %0d slot %0d", st, sl);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            errors++;
         end
         if (sl !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, sl);
            errors++;
         end
         seen[int'(want.status)]++;
         checked++;
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;
   bit                steady;
   int                cycle_count;
   int                sent;
   int                size_writes;
   int                drains;
   logic [KEY_W-1:0]  key_pool [16];

   key_table_scoreboard sb;

   oakt_req_if req_bus ();
   oakt_rsp_if rsp_bus ();

   open_address_key_table dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= reset ? 1'b0 : (steady || $urandom_range(99) >= 21);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         sb.check_response(rsp_bus.status, rsp_bus.slot);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: done, errors");
      $finish;
   end

   // Called just after a falling edge; returns just after a falling edge.
   task automatic send_request(input logic act, input logic [KEY_W-1:0] k);
      bit taken;
      while (!steady && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.key <= k;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
      end
      sb.note_request(act, k);
      sent++;
      @(negedge clock);
   endtask

   // Hold off new requests until every response is back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      drains++;
   endtask

   task automatic write_table_size(input logic [SIZE_W-1:0] v);
      drain();
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_size(v);
      size_writes++;
   endtask

   function automatic logic [KEY_W-1:0] pick_key(input int n);
      int r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(99);
      if (r < 4) k = '0;
      else if (r < 40) k = KEY_W'($urandom);
      // Crowd a few home slots so that probe chains grow long.
      else if (r < 70) k = KEY_W'($urandom_range(3) + n * $urandom_range(200));
      else k = key_pool[$urandom_range(15)];
      return k;
   endfunction

   initial begin
      int phase_sizes [PHASE_COUNT];
      int p;
      int j;
      logic act;
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] stored;

      phase_sizes = '{2, 255, 0, 1, 31, 3, 7, 16, 64, 128, 254, 255, 0};
      phase_sizes[PHASE_COUNT-1] = $urandom_range(255);
      foreach (key_pool[m]) key_pool[m] = KEY_W'($urandom_range(65535, 1));
      sb = new();
      sent = 0;
      size_writes = 0;
      drains = 0;
      steady = 1'b0;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_INSERT;
      req_bus.key = '0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero key, extreme keys, found and missed removes at the reset size.
      send_request(ACT_INSERT, 16'h0000);
      send_request(ACT_REMOVE, 16'h0000);
      send_request(ACT_INSERT, 16'hFFFF);
      send_request(ACT_REMOVE, 16'hFFFF);
      send_request(ACT_REMOVE, 16'hFFFF);
      send_request(ACT_INSERT, 16'h0001);
      // A zero register acts as one slot.
      write_table_size(8'd0);
      send_request(ACT_INSERT, 16'd7);
      send_request(ACT_INSERT, 16'd9);
      send_request(ACT_REMOVE, 16'd9);
      send_request(ACT_REMOVE, 16'd7);
      write_table_size(8'd1);
      send_request(ACT_INSERT, 16'd3);
      send_request(ACT_INSERT, 16'd3);
      // With five slots a chain from home zero never reaches slots two and four.
      write_table_size(8'd5);
      send_request(ACT_INSERT, 16'd5);
      send_request(ACT_INSERT, 16'd10);
      send_request(ACT_INSERT, 16'd5);
      send_request(ACT_INSERT, 16'd15);
      send_request(ACT_INSERT, 16'd2);
      send_request(ACT_REMOVE, 16'd10);
      send_request(ACT_INSERT, 16'd20);
      // Shrink: old contents stay, upper slots drop out of the probe range.
      write_table_size(8'd3);
      send_request(ACT_REMOVE, 16'd15);
      send_request(ACT_REMOVE, 16'd5);
      send_request(ACT_INSERT, 16'h8000);

      for (p = 0; p < PHASE_COUNT; p++) begin
         write_table_size(SIZE_W'(phase_sizes[p]));
         steady = (p == 4);
         for (j = 0; j < PHASE_ITEMS; j++) begin
            act = ($urandom_range(99) < 45) ? ACT_REMOVE : ACT_INSERT;
            k = pick_key(sb.span());
            if (act == ACT_REMOVE && $urandom_range(99) < 70) begin
               stored = sb.pick_stored();
               if (stored != '0) k = stored;
            end
            send_request(act, k);
            if ($urandom_range(49) == 0) drain();
         end
      end
      steady = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.errors += sb.pending();
      end
      $display("tb: %0d requests, %0d responses checked, %0d size writes, %0d drains",
               sent, sb.checked, size_writes, drains);
      $display("tb: inserted %0d, full %0d, removed %0d, not found %0d, zero key %0d",
               sb.seen[int'(ST_INSERTED)], sb.seen[int'(ST_FULL)],
               sb.seen[int'(ST_REMOVED)], sb.seen[int'(ST_NOT_FOUND)],
               sb.seen[int'(ST_ZERO_KEY)]);
      if (sb.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
